>>> rtl/potts_site_propensity_select_defines.svh
// Assertion macros shared by the site propensity RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef POTTS_SITE_PROPENSITY_SELECT_DEFINES_SVH
`define POTTS_SITE_PROPENSITY_SELECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSPS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psps: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSPS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psps: next-cycle check failed");

`endif

>>> rtl/psps_pkg.sv
// Types and constants for the Potts site propensity and spin selection block.
// Used by potts_site_propensity_select; depends on nothing else.
package psps_pkg;

	localparam int unsigned NUM_NEIGH = 6;
	localparam int unsigned SPIN_W    = 16;
	localparam int unsigned FACTOR_W  = 17;
	localparam int unsigned SUM_W     = 19;
	localparam int unsigned ACC_W     = 20;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [FACTOR_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic [SUM_W-1:0]    SUM_MAX = 19'h7FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOLTZ_1 = 3'd0,
		CFG_BOLTZ_2 = 3'd1,
		CFG_BOLTZ_3 = 3'd2,
		CFG_BOLTZ_4 = 3'd3,
		CFG_BOLTZ_5 = 3'd4,
		CFG_BOLTZ_6 = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic              mode;
		logic [SPIN_W-1:0] center_spin;
		logic [SPIN_W-1:0] spin_xm;
		logic [SPIN_W-1:0] spin_xp;
		logic [SPIN_W-1:0] spin_ym;
		logic [SPIN_W-1:0] spin_yp;
		logic [SPIN_W-1:0] spin_zm;
		logic [SPIN_W-1:0] spin_zp;
		logic [SUM_W-1:0]  threshold;
	} site_t;

	typedef struct packed {
		logic [SUM_W-1:0]  prob_sum;
		logic [SPIN_W-1:0] new_spin;
		logic [CNT_W-1:0]  candidate_count;
	} result_t;

endpackage

>>> rtl/potts_site_propensity_select.sv
// Potts site propensity and spin selection for one simple cubic lattice site.
// Pipeline: a site taken on start passes the input, match, prefix-sum and result
// registers in turn, and its result leaves the last of them with done high.
// Throughput: one site per cycle; busy is always low and the receiver cannot stall.
// Reset: arst_n clears all valid bits and the six Boltzmann factors to zero.
`include "potts_site_propensity_select_defines.svh"

module potts_site_propensity_select #(
	parameter int unsigned SPIN_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  psps_pkg::site_t                      site,
	output logic                                 done,
	output psps_pkg::result_t                    result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [psps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psps_pkg::FACTOR_W-1:0]        cfg_data
);

	localparam int unsigned N = psps_pkg::NUM_NEIGH;
	localparam int unsigned SW = psps_pkg::SPIN_W;
	localparam logic [SW-1:0] SPIN_MASK = (SPIN_BITS >= SW) ? {SW{1'b1}} :
		SW'((33'd1 << SPIN_BITS) - 33'd1);

	// Configuration registers.
	logic [N-1:0][psps_pkg::FACTOR_W-1:0] boltz_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boltz_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				psps_pkg::CFG_BOLTZ_1: boltz_q[0] <= cfg_data;
				psps_pkg::CFG_BOLTZ_2: boltz_q[1] <= cfg_data;
				psps_pkg::CFG_BOLTZ_3: boltz_q[2] <= cfg_data;
				psps_pkg::CFG_BOLTZ_4: boltz_q[3] <= cfg_data;
				psps_pkg::CFG_BOLTZ_5: boltz_q[4] <= cfg_data;
				psps_pkg::CFG_BOLTZ_6: boltz_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: registered input, spins masked to their compared width.
	logic                              v_s1;
	logic                              mode_s1;
	logic [SW-1:0]                     center_s1;
	logic [N-1:0][SW-1:0]              nb_s1;
	logic [psps_pkg::SUM_W-1:0]        thr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1   <= site.mode;
		center_s1 <= site.center_spin & SPIN_MASK;
		nb_s1[0]  <= site.spin_xm & SPIN_MASK;
		nb_s1[1]  <= site.spin_xp & SPIN_MASK;
		nb_s1[2]  <= site.spin_ym & SPIN_MASK;
		nb_s1[3]  <= site.spin_yp & SPIN_MASK;
		nb_s1[4]  <= site.spin_zm & SPIN_MASK;
		nb_s1[5]  <= site.spin_zp & SPIN_MASK;
		thr_s1    <= site.threshold;
	end

	// Stage 2: candidate flags and the propensity each candidate contributes.
	// A candidate's energy rise over the center equals how many more neighbors
	// match the center than match the candidate.
	logic [N-1:0]                          cand_c;
	logic [N-1:0][psps_pkg::FACTOR_W-1:0]  add_c;

	always_comb begin
		logic [N-1:0]                     eq_ctr;
		logic [N-1:0][N-1:0]              match;
		logic [psps_pkg::CNT_W-1:0]       cnt_ctr;
		logic [psps_pkg::CNT_W-1:0]       cnt_nb;
		logic [psps_pkg::CNT_W-1:0]       rise;
		logic                             seen;
		for (int m = 0; m < N; m++) begin
			eq_ctr[m] = (nb_s1[m] == center_s1);
			for (int j = 0; j < N; j++) begin
				match[m][j] = (nb_s1[m] == nb_s1[j]);
			end
		end
		cnt_ctr = psps_pkg::CNT_W'($countones(eq_ctr));
		for (int m = 0; m < N; m++) begin
			seen = 1'b0;
			for (int j = 0; j < m; j++) begin
				seen = seen | match[m][j];
			end
			cand_c[m] = !eq_ctr[m] && !seen;
			cnt_nb    = psps_pkg::CNT_W'($countones(match[m]));
			rise      = cnt_ctr - cnt_nb - 3'd1;
			if (!cand_c[m]) begin
				add_c[m] = '0;
			end else if (cnt_nb >= cnt_ctr) begin
				add_c[m] = psps_pkg::ONE_Q16;
			end else begin
				add_c[m] = boltz_q[rise];
			end
		end
	end

	logic                                  v_s2;
	logic                                  mode_s2;
	logic [SW-1:0]                         center_s2;
	logic [N-1:0][SW-1:0]                  nb_s2;
	logic [psps_pkg::SUM_W-1:0]            thr_s2;
	logic [N-1:0]                          cand_s2;
	logic [N-1:0][psps_pkg::FACTOR_W-1:0]  add_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s2   <= mode_s1;
		center_s2 <= center_s1;
		nb_s2     <= nb_s1;
		thr_s2    <= thr_s1;
		cand_s2   <= cand_c;
		add_s2    <= add_c;
	end

	// Stage 3: saturated running sums. Non-candidates add zero, so the sum at
	// each position is the running sum at the latest candidate up to there.
	logic [N-1:0][psps_pkg::SUM_W-1:0] pre_c;

	always_comb begin
		logic [psps_pkg::ACC_W-1:0] acc;
		acc = '0;
		for (int m = 0; m < N; m++) begin
			acc = acc + psps_pkg::ACC_W'(add_s2[m]);
			pre_c[m] = (acc > psps_pkg::ACC_W'(psps_pkg::SUM_MAX)) ? psps_pkg::SUM_MAX :
				acc[psps_pkg::SUM_W-1:0];
		end
	end

	logic                               v_s3;
	logic                               mode_s3;
	logic [SW-1:0]                      center_s3;
	logic [N-1:0][SW-1:0]               nb_s3;
	logic [psps_pkg::SUM_W-1:0]         thr_s3;
	logic [N-1:0]                       cand_s3;
	logic [N-1:0][psps_pkg::SUM_W-1:0]  pre_s3;
	logic [psps_pkg::CNT_W-1:0]         cnt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mode_s3   <= mode_s2;
		center_s3 <= center_s2;
		nb_s3     <= nb_s2;
		thr_s3    <= thr_s2;
		cand_s3   <= cand_s2;
		pre_s3    <= pre_c;
		cnt_s3    <= psps_pkg::CNT_W'($countones(cand_s2));
	end

	// Result: in pick mode take the first candidate whose running sum reaches
	// the threshold, falling back to the last candidate, then to the center.
	psps_pkg::result_t res_c;

	always_comb begin
		logic                               hit;
		logic                               any;
		logic [psps_pkg::CNT_W-1:0]         hit_idx;
		logic [psps_pkg::CNT_W-1:0]         last_idx;
		hit      = 1'b0;
		any      = 1'b0;
		hit_idx  = '0;
		last_idx = '0;
		for (int m = N - 1; m >= 0; m--) begin
			if (cand_s3[m] && (pre_s3[m] >= thr_s3)) begin
				hit     = 1'b1;
				hit_idx = psps_pkg::CNT_W'(m);
			end
		end
		for (int m = 0; m < N; m++) begin
			if (cand_s3[m]) begin
				any      = 1'b1;
				last_idx = psps_pkg::CNT_W'(m);
			end
		end
		res_c.candidate_count = cnt_s3;
		res_c.prob_sum        = pre_s3[N-1];
		res_c.new_spin        = center_s3;
		if (mode_s3) begin
			if (hit) begin
				res_c.prob_sum = pre_s3[hit_idx];
				res_c.new_spin = nb_s3[hit_idx];
			end else if (any) begin
				res_c.new_spin = nb_s3[last_idx];
			end
		end
	end

	logic done_q;
	psps_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	assign done   = done_q;
	assign result = result_q;

	`PSPS_ASSERT_IMP(a_done_follows_start, done, $past(start, 4))
	`PSPS_ASSERT_IMP(a_no_cand_zero_sum, done && (result.candidate_count == '0), result.prob_sum == '0)
	`PSPS_ASSERT_NXT(a_total_mode_keeps_center, v_s3 && !mode_s3, done && (result.new_spin == $past(center_s3)))

endmodule

>>> tb/sv/psps_site_checker.sv
`timescale 1ns / 100ps
// Scoreboard for potts_site_propensity_select: mode codes and a checker module.
// Depends on psps_pkg; tb.sv instantiates the checker beside the block.
package psps_tb_pkg;

	localparam logic MODE_TOTAL = 1'b0;
	localparam logic MODE_PICK  = 1'b1;

endpackage

module psps_site_checker
	import psps_pkg::*, psps_tb_pkg::*;
#(
	parameter int unsigned SPIN_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  site_t                site,
	input  logic                 done,
	input  result_t              result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FACTOR_W-1:0]  cfg_data,
	output int                   mismatch_count,
	output int                   outstanding
);

	logic [FACTOR_W-1:0] boltz_factor [NUM_NEIGH];
	result_t             pending_results [$];
	int                  fail_tally = 0;

	assign mismatch_count = fail_tally;

	function automatic int count_unequal(input logic [SPIN_W-1:0] s,
			input logic [NUM_NEIGH-1:0][SPIN_W-1:0] nb);
		int n;
		n = 0;
		for (int m = 0; m < NUM_NEIGH; m++) begin
			if (nb[m] != s)
				n++;
		end
		return n;
	endfunction

	// Candidates are the distinct neighbor spins unlike the center, in order of first
	// appearance; each adds 1.0 unless it raises the energy, then its Boltzmann factor.
	function automatic result_t predict_site(input site_t s);
		logic [SPIN_W-1:0]                 msk;
		logic [SPIN_W-1:0]                 ctr;
		logic [SPIN_W-1:0]                 pick;
		logic [NUM_NEIGH-1:0][SPIN_W-1:0] nb;
		logic [NUM_NEIGH-1:0][SPIN_W-1:0] cand;
		logic [ACC_W-1:0]                  sum;
		logic [FACTOR_W-1:0]               add;
		int                                ncand;
		int                                e_ctr;
		int                                e_cand;
		bit                                seen;
		bit                                stop;
		result_t                           r;
		msk = (SPIN_BITS >= SPIN_W) ? '1 : SPIN_W'((32'd1 << SPIN_BITS) - 1);
		ctr = s.center_spin & msk;
		nb = {s.spin_zp, s.spin_zm, s.spin_yp, s.spin_ym, s.spin_xp, s.spin_xm};
		cand = '0;
		ncand = 0;
		for (int m = 0; m < NUM_NEIGH; m++) begin
			nb[m] = nb[m] & msk;
		end
		for (int m = 0; m < NUM_NEIGH; m++) begin
			seen = 1'b0;
			for (int c = 0; c < ncand; c++) begin
				if (cand[c] == nb[m])
					seen = 1'b1;
			end
			if (nb[m] != ctr && !seen) begin
				cand[ncand] = nb[m];
				ncand++;
			end
		end
		e_ctr = count_unequal(ctr, nb);
		sum = '0;
		pick = ctr;
		stop = 1'b0;
		for (int c = 0; c < ncand; c++) begin
			if (!stop) begin
				e_cand = count_unequal(cand[c], nb);
				if (e_cand <= e_ctr)
					add = ONE_Q16;
				else
					add = boltz_factor[(e_cand - e_ctr - 1) % NUM_NEIGH];
				sum = sum + add;
				if (sum > SUM_MAX)
					sum = SUM_MAX;
				if (s.mode == MODE_PICK) begin
					pick = cand[c];
					if (sum >= s.threshold)
						stop = 1'b1;
				end
			end
		end
		r.prob_sum = sum[SUM_W-1:0];
		r.new_spin = (s.mode == MODE_PICK) ? pick : ctr;
		r.candidate_count = CNT_W'(ncand);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_NEIGH; i++)
				boltz_factor[i] = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if ($isunknown(done)) begin
				$display("%0t: done expected 0 or 1, actual %b", $time, done);
				fail_tally++;
			end else if (done) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result expected none, actual %p", $time, result);
					fail_tally++;
				end else begin
					want = pending_results.pop_front();
					if (result.prob_sum !== want.prob_sum) begin
						$display("%0t: prob_sum expected %0d, actual %0d", $time,
							want.prob_sum, result.prob_sum);
						fail_tally++;
					end
					if (result.new_spin !== want.new_spin) begin
						$display("%0t: new_spin expected %0d, actual %0d", $time,
							want.new_spin, result.new_spin);
						fail_tally++;
					end
					if (result.candidate_count !== want.candidate_count) begin
						$display("%0t: candidate_count expected %0d, actual %0d", $time,
							want.candidate_count, result.candidate_count);
						fail_tally++;
					end
				end
			end
			// Indexes past the last factor are ignored by the block.
			if (cfg_valid && cfg_ready && cfg_index < NUM_NEIGH)
				boltz_factor[cfg_index] = cfg_data;
			// One transaction in, one result out, in order.
			if (start && !busy)
				pending_results.push_back(predict_site(site));
			outstanding <= pending_results.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the potts_site_propensity_select testbench: clock, reset, stimulus and verdict.
// Depends on psps_pkg, the block itself and psps_site_checker.
module tb;

	import psps_pkg::*;
	import psps_tb_pkg::*;

	localparam int unsigned SPIN_BITS = 16;
	localparam int LATENCY          = 4;
	localparam int IDLE_LIMIT       = 2000;
	localparam int RANDOM_PHASES    = 8;
	localparam int SITES_PER_PHASE  = 125;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	site_t                site;
	logic                 done;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FACTOR_W-1:0]  cfg_data;
	int                   mismatch_count;
	int                   outstanding;
	int                   idle_cycles = 0;
	bit                   steady = 1'b0;
	logic [FACTOR_W-1:0]  factor_plan [NUM_NEIGH];

	potts_site_propensity_select #(
		.SPIN_BITS(SPIN_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.site(site),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	psps_site_checker #(
		.SPIN_BITS(SPIN_BITS)
	) site_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.site(site),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL potts_site_propensity_select");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Mostly back to back or short pauses, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic site_t make_site(input logic mode, input logic [SPIN_W-1:0] c,
			input logic [SPIN_W-1:0] xm, input logic [SPIN_W-1:0] xp,
			input logic [SPIN_W-1:0] ym, input logic [SPIN_W-1:0] yp,
			input logic [SPIN_W-1:0] zm, input logic [SPIN_W-1:0] zp,
			input logic [SUM_W-1:0] thr);
		site_t s;
		s.mode = mode;
		s.center_spin = c;
		s.spin_xm = xm;
		s.spin_xp = xp;
		s.spin_ym = ym;
		s.spin_yp = yp;
		s.spin_zm = zm;
		s.spin_zp = zp;
		s.threshold = thr;
		return s;
	endfunction

	// Spins mostly come from a small palette so that neighbors repeat and energies vary.
	function automatic site_t random_site();
		logic [SPIN_W-1:0] pal [4];
		int                npal;
		int                kind;
		int                r;
		site_t             s;
		npal = $urandom_range(1, 4);
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 4; i++) begin
			r = $urandom_range(0, 7);
			if (r == 0)
				pal[i] = '0;
			else if (r == 1)
				pal[i] = '1;
			else if (r == 2)
				pal[i] = SPIN_W'($urandom_range(0, 3));
			else
				pal[i] = SPIN_W'($urandom);
		end
		s = site_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		if (kind < 8) begin
			s.spin_xm = pal[$urandom_range(0, npal - 1)];
			s.spin_xp = pal[$urandom_range(0, npal - 1)];
			s.spin_ym = pal[$urandom_range(0, npal - 1)];
			s.spin_yp = pal[$urandom_range(0, npal - 1)];
			s.spin_zm = pal[$urandom_range(0, npal - 1)];
			s.spin_zp = pal[$urandom_range(0, npal - 1)];
			if (kind < 6)
				s.center_spin = pal[0];
		end
		s.mode = ($urandom_range(0, 1) == 0) ? MODE_TOTAL : MODE_PICK;
		r = $urandom_range(0, 9);
		if (r == 0)
			s.threshold = '0;
		else if (r == 1)
			s.threshold = '1;
		else if (r == 2)
			s.threshold = SUM_W'($urandom);
		else if (r == 3)
			s.threshold = SUM_W'(ONE_Q16) * SUM_W'($urandom_range(0, NUM_NEIGH));
		else
			s.threshold = SUM_W'($urandom_range(0, NUM_NEIGH * ONE_Q16));
		return s;
	endfunction

	task automatic send_site(input site_t s);
		int gap;
		start <= 1'b1;
		site <= s;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			site <= site_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
			repeat (gap) @(posedge clk);
		end
	endtask

	// The checker's count is registered, so look only after the last start has settled.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic program_factors(input bit poke_unmapped);
		int gap;
		int writes;
		writes = poke_unmapped ? (1 << CFG_IDX_W) : NUM_NEIGH;
		for (int i = 0; i < writes; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= (i < NUM_NEIGH) ? factor_plan[i] : FACTOR_W'($urandom);
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				cfg_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		send_site(make_site(MODE_TOTAL, 16'h5A5A, 16'h5A5A, 16'h5A5A, 16'h5A5A,
			16'h5A5A, 16'h5A5A, 16'h5A5A, '0));
		send_site(make_site(MODE_PICK, 16'h5A5A, 16'h5A5A, 16'h5A5A, 16'h5A5A,
			16'h5A5A, 16'h5A5A, 16'h5A5A, '0));
		send_site(make_site(MODE_TOTAL, 16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5,
			16'h0001, 16'h8000, 16'h7FFF, '1));
		send_site(make_site(MODE_PICK, 16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5,
			16'h0001, 16'h8000, 16'h7FFF, '0));
		send_site(make_site(MODE_PICK, 16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5,
			16'h0001, 16'h8000, 16'h7FFF, '1));
		// Threshold lands exactly on the running sum at the third candidate.
		send_site(make_site(MODE_PICK, 16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5,
			16'h0001, 16'h8000, 16'h7FFF, SUM_W'(ONE_Q16) * SUM_W'(3)));
		send_site(make_site(MODE_TOTAL, 16'h5A5A, 16'h5A5A, 16'h5A5A, 16'h5A5A,
			16'h5A5A, 16'h5A5A, 16'hFFFF, '0));
		send_site(make_site(MODE_PICK, 16'h5A5A, 16'h5A5A, 16'h5A5A, 16'hA5A5,
			16'hA5A5, 16'h0001, 16'h8000, '1));
		send_site(make_site(MODE_TOTAL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h5A5A,
			16'hA5A5, 16'h0001, 16'h8000, '0));
		send_site(make_site(MODE_PICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'hFFFF, 16'h5A5A, 16'hA5A5, SUM_W'(1)));
		send_site(make_site(MODE_TOTAL, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
			16'h0001, 16'hFFFF, 16'hFFFF, '0));
		send_site(make_site(MODE_PICK, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'h0000, 16'hFFFF, 16'hFFFF, SUM_W'(ONE_Q16) + SUM_W'(1)));
	endtask

	initial begin
		logic [FACTOR_W-1:0] f1;
		arst_n = 1'b0;
		start = 1'b0;
		site = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero temperature straight out of reset, then a falling set of factors.
		run_directed();
		drain();
		factor_plan[CFG_BOLTZ_1] = ONE_Q16;
		factor_plan[CFG_BOLTZ_2] = 17'd40000;
		factor_plan[CFG_BOLTZ_3] = 17'd20000;
		factor_plan[CFG_BOLTZ_4] = 17'd9000;
		factor_plan[CFG_BOLTZ_5] = 17'd3000;
		factor_plan[CFG_BOLTZ_6] = 17'd1;
		program_factors(1'b0);
		run_directed();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			steady = (p == 3);
			f1 = FACTOR_W'($urandom_range(0, ONE_Q16));
			for (int i = 0; i < NUM_NEIGH; i++) begin
				case (p)
					0: factor_plan[i] = ONE_Q16;
					1: factor_plan[i] = '0;
					2: factor_plan[i] = FACTOR_W'($urandom);
					3: factor_plan[i] = '1;
					default: begin
						if (i == 0)
							factor_plan[i] = f1;
						else
							factor_plan[i] = FACTOR_W'((64'(factor_plan[i - 1]) * f1) >> 16);
					end
				endcase
			end
			program_factors(p == 2 || p == 5);
			for (int n = 0; n < SITES_PER_PHASE; n++)
				send_site(random_site());
		end

		drain();
		repeat (LATENCY + 6) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("PASS potts_site_propensity_select");
		else
			$display("FAIL potts_site_propensity_select");
		$finish;
	end

endmodule
